### hw/rtl/ssvm_pkg.sv
package ssvm_pkg;

  localparam int unsigned SmpW  = 16;
  localparam int unsigned AddrW = 16;
  localparam int unsigned LenW  = 17;
  localparam int unsigned TimeW = 24;
  localparam int unsigned GainW = 16;
  localparam int unsigned RateW = 18;
  localparam int unsigned RemW  = 32;
  localparam int unsigned CntOutW = 8;
  localparam int unsigned PosW  = 21;
  localparam logic [RateW-1:0] RateReset = 18'd48000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PLAY  = 2'd1,
    OP_SHIFT = 2'd2,
    OP_FRAME = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_CLIPPED = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAPTURED,
    S_LOAD,
    S_PMUL,
    S_PLAY,
    S_SHIFT,
    S_VRD,
    S_VDATA,
    S_SMP,
    S_ACC,
    S_FEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [AddrW-1:0]        address;
    logic [LenW-1:0]         sound_length;
    logic signed [SmpW-1:0]  sample_value;
    logic signed [TimeW-1:0] time_value;
    logic [GainW-1:0]        gain_left;
    logic [GainW-1:0]        gain_right;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0]       base;
    logic [LenW-1:0]        len;
    logic signed [RemW-1:0] rem;
    logic [GainW-1:0]       gl;
    logic [GainW-1:0]       gr;
  } voice_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic play_mul;
    logic play_wr;
    logic shift_upd;
    logic voice_rd;
    logic voice_eval;
    logic smp_mul;
    logic acc;
    logic frm_end;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic count_zero;
    logic last_voice;
  } sts_t;

endpackage

### hw/rtl/ssvm_if.sv
interface ssvm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              opcode;
  logic [ssvm_pkg::AddrW-1:0]              address;
  logic [ssvm_pkg::LenW-1:0]               sound_length;
  logic signed [ssvm_pkg::SmpW-1:0]        sample_value;
  logic signed [ssvm_pkg::TimeW-1:0]       time_value;
  logic [ssvm_pkg::GainW-1:0]              gain_left;
  logic [ssvm_pkg::GainW-1:0]              gain_right;
  modport source (output valid, opcode, address, sound_length, sample_value, time_value,
                  gain_left, gain_right, input ready);
  modport sink (input valid, opcode, address, sound_length, sample_value, time_value,
                gain_left, gain_right, output ready);
endinterface

interface ssvm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ssvm_pkg::SmpW-1:0] left_out;
  logic signed [ssvm_pkg::SmpW-1:0] right_out;
  logic [1:0]                       status;
  logic [ssvm_pkg::CntOutW-1:0]     active_voices;
  modport source (output valid, left_out, right_out, status, active_voices, input ready);
  modport sink (input valid, left_out, right_out, status, active_voices, output ready);
endinterface

interface ssvm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ssvm_pkg::RateW-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/ssvm_ctrl.sv
module ssvm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ssvm_pkg::sts_t sts,
  output ssvm_pkg::cmd_t cmd
);

  ssvm_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssvm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ssvm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ssvm_pkg::S_CAPTURED;
        end
      end
      ssvm_pkg::S_CAPTURED: begin
        unique case (sts.op)
          ssvm_pkg::OP_LOAD:  state_nxt = ssvm_pkg::S_LOAD;
          ssvm_pkg::OP_PLAY:  state_nxt = sts.full ? ssvm_pkg::S_DONE : ssvm_pkg::S_PMUL;
          ssvm_pkg::OP_SHIFT: state_nxt = ssvm_pkg::S_PMUL;
          ssvm_pkg::OP_FRAME: state_nxt = sts.count_zero ? ssvm_pkg::S_FEND : ssvm_pkg::S_VRD;
          default:            state_nxt = ssvm_pkg::S_DONE;
        endcase
      end
      ssvm_pkg::S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ssvm_pkg::S_DONE;
      end
      ssvm_pkg::S_PMUL: begin
        cmd.play_mul = 1'b1;
        state_nxt    = (sts.op == ssvm_pkg::OP_PLAY) ? ssvm_pkg::S_PLAY : ssvm_pkg::S_SHIFT;
      end
      ssvm_pkg::S_PLAY: begin
        cmd.play_wr = 1'b1;
        state_nxt   = ssvm_pkg::S_DONE;
      end
      ssvm_pkg::S_SHIFT: begin
        cmd.shift_upd = 1'b1;
        state_nxt     = ssvm_pkg::S_DONE;
      end
      ssvm_pkg::S_VRD: begin
        cmd.voice_rd = 1'b1;
        state_nxt    = ssvm_pkg::S_VDATA;
      end
      ssvm_pkg::S_VDATA: begin
        cmd.voice_eval = 1'b1;
        state_nxt      = ssvm_pkg::S_SMP;
      end
      ssvm_pkg::S_SMP: begin
        cmd.smp_mul = 1'b1;
        state_nxt   = ssvm_pkg::S_ACC;
      end
      ssvm_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_voice ? ssvm_pkg::S_FEND : ssvm_pkg::S_VRD;
      end
      ssvm_pkg::S_FEND: begin
        cmd.frm_end = 1'b1;
        state_nxt   = ssvm_pkg::S_DONE;
      end
      ssvm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ssvm_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssvm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/ssvm_dp.sv
module ssvm_dp #(
  parameter int unsigned VOICES       = 128,
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssvm_pkg::cmd_t                     cmd,
  output ssvm_pkg::sts_t                     sts,
  input  ssvm_pkg::item_t                    item,
  input  logic                               cfg_we,
  input  logic [ssvm_pkg::RateW-1:0]         cfg_data,
  output logic signed [ssvm_pkg::SmpW-1:0]   left_out,
  output logic signed [ssvm_pkg::SmpW-1:0]   right_out,
  output logic [1:0]                         status,
  output logic [ssvm_pkg::CntOutW-1:0]       active_voices
);

  localparam int unsigned VIW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW   = $clog2(VOICES + 1);
  localparam int unsigned AW   = $clog2(SAMPLE_DEPTH);
  localparam int unsigned ProdW = ssvm_pkg::TimeW + ssvm_pkg::RateW + 1;
  localparam int unsigned MixW = ssvm_pkg::SmpW + ssvm_pkg::GainW + 1;
  localparam int unsigned AccW = MixW + VIW + 1;

  // Memories.
  logic signed [ssvm_pkg::SmpW-1:0] smem [SAMPLE_DEPTH];
  ssvm_pkg::voice_t                 vmem [VOICES];

  ssvm_pkg::item_t item_r;
  logic [ssvm_pkg::RateW-1:0] rate_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] tz_r, tz_nxt;
  logic [VIW-1:0] q_r;
  logic [CW-1:0] w_r;
  logic signed [ProdW-1:0] tprod_r;
  ssvm_pkg::voice_t vrd_r;
  logic signed [ssvm_pkg::SmpW-1:0] srd_r;
  logic sounding_r;
  logic [ssvm_pkg::GainW-1:0] gl_r, gr_r;
  logic signed [MixW-1:0] pl_r, pr_r;
  logic signed [AccW-1:0] accl_r, accr_r;
  logic signed [ssvm_pkg::SmpW-1:0] resl_r, resr_r;
  logic [1:0] res_st_r;

  // Time conversion, rounding toward zero.
  logic signed [ProdW-1:0] tprod_adj;
  logic signed [31:0] n_samp;
  logic signed [33:0] start_s;
  logic signed [34:0] end_s;
  logic signed [ssvm_pkg::RemW-1:0] end_sat;

  always_comb begin
    tprod_adj = tprod_r[ProdW-1] ? (tprod_r + ProdW'(4095)) : tprod_r;
    n_samp    = 32'(tprod_adj >>> 12);
    start_s   = 34'($signed(tz_r)) + 34'(n_samp);
    if (start_s < 0) begin
      start_s = '0;
    end
    end_s = 35'(start_s) + 35'($signed({1'b0, item_r.sound_length}));
    if (end_s > 35'sh7FFFFFFF) begin
      end_sat = 32'sh7FFFFFFF;
    end else begin
      end_sat = end_s[31:0];
    end
  end

  // Voice evaluation.
  logic signed [ssvm_pkg::RemW-1:0] rem_dec;
  logic signed [ssvm_pkg::RemW:0] len_s;
  logic sounding;
  logic [ssvm_pkg::PosW-1:0] pos;

  always_comb begin
    len_s    = $signed({16'd0, vrd_r.len});
    rem_dec  = vrd_r.rem - 32'sd1;
    sounding = (vrd_r.rem >= 32'sd1) && (33'(vrd_r.rem) <= len_s);
    pos      = ssvm_pkg::PosW'(vrd_r.base) + ssvm_pkg::PosW'(vrd_r.len)
             - ssvm_pkg::PosW'(vrd_r.rem[ssvm_pkg::LenW-1:0]);
  end

  // Final mix.
  logic signed [AccW-1:0] fl, fr;
  logic signed [ssvm_pkg::SmpW-1:0] sl, sr;
  logic clip_l, clip_r;

  always_comb begin
    fl = accl_r >>> 14;
    fr = accr_r >>> 14;
    clip_l = 1'b1;
    clip_r = 1'b1;
    if (fl > AccW'(32767)) begin
      sl = 16'sh7FFF;
    end else if (fl < -AccW'(32768)) begin
      sl = -16'sh8000;
    end else begin
      sl = fl[15:0];
      clip_l = 1'b0;
    end
    if (fr > AccW'(32767)) begin
      sr = 16'sh7FFF;
    end else if (fr < -AccW'(32768)) begin
      sr = -16'sh8000;
    end else begin
      sr = fr[15:0];
      clip_r = 1'b0;
    end
  end

  logic [ssvm_pkg::PosW-1:0] load_addr;
  assign load_addr = ssvm_pkg::PosW'(item_r.address);

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      smem[load_addr[AW-1:0]] <= item_r.sample_value;
    end
    if (cmd.voice_eval) begin
      srd_r <= smem[pos[AW-1:0]];
    end
  end

  logic vwe;
  logic [VIW-1:0] vwaddr;
  ssvm_pkg::voice_t vwdata;

  always_comb begin
    vwe    = 1'b0;
    vwaddr = count_r[VIW-1:0];
    vwdata = vrd_r;
    if (cmd.play_wr) begin
      vwe         = 1'b1;
      vwdata.base = item_r.address;
      vwdata.len  = item_r.sound_length;
      vwdata.rem  = end_sat;
      vwdata.gl   = item_r.gain_left;
      vwdata.gr   = item_r.gain_right;
    end else if (cmd.voice_eval && (rem_dec > 32'sd0)) begin
      vwe        = 1'b1;
      vwaddr     = w_r[VIW-1:0];
      vwdata.rem = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    if (cmd.voice_rd) begin
      vrd_r <= vmem[q_r];
    end
  end

  always_comb begin
    count_nxt = count_r;
    tz_nxt    = tz_r;
    if (cmd.play_wr) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.shift_upd) begin
      tz_nxt = tz_r + n_samp;
    end
    if (cmd.frm_end) begin
      count_nxt = w_r;
      tz_nxt    = tz_r - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tz_r    <= '0;
      rate_r  <= ssvm_pkg::RateReset;
    end else begin
      count_r <= count_nxt;
      tz_r    <= tz_nxt;
      if (cfg_we) begin
        rate_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= item;
      q_r      <= '0;
      w_r      <= '0;
      accl_r   <= '0;
      accr_r   <= '0;
      resl_r   <= '0;
      resr_r   <= '0;
      res_st_r <= ((item.opcode == ssvm_pkg::OP_PLAY) && (count_r == CW'(VOICES)))
                  ? ssvm_pkg::ST_DROPPED : ssvm_pkg::ST_OK;
    end
    if (cmd.play_mul) begin
      tprod_r <= ProdW'(item_r.time_value) * $signed({1'b0, rate_r});
    end
    if (cmd.voice_eval) begin
      sounding_r <= sounding;
      gl_r       <= vrd_r.gl;
      gr_r       <= vrd_r.gr;
      if (rem_dec > 32'sd0) begin
        w_r <= w_r + CW'(1);
      end
    end
    if (cmd.smp_mul) begin
      pl_r <= sounding_r ? MixW'(srd_r * $signed({1'b0, gl_r})) : '0;
      pr_r <= sounding_r ? MixW'(srd_r * $signed({1'b0, gr_r})) : '0;
    end
    if (cmd.acc) begin
      accl_r <= accl_r + AccW'(pl_r);
      accr_r <= accr_r + AccW'(pr_r);
      q_r    <= q_r + VIW'(1);
    end
    if (cmd.frm_end) begin
      resl_r   <= sl;
      resr_r   <= sr;
      res_st_r <= (clip_l || clip_r) ? ssvm_pkg::ST_CLIPPED : ssvm_pkg::ST_OK;
    end
    if (cmd.out_load) begin
      left_out      <= resl_r;
      right_out     <= resr_r;
      status        <= res_st_r;
      active_voices <= ssvm_pkg::CntOutW'(count_r);
    end
  end

  assign sts.op         = ssvm_pkg::op_t'(item_r.opcode);
  assign sts.full       = (count_r == CW'(VOICES));
  assign sts.count_zero = (count_r == '0);
  assign sts.last_voice = ((CW'(q_r) + CW'(1)) == count_r);

endmodule

### hw/rtl/scheduled_sample_voice_mixer_core.sv
// Stereo sample-playback mixer. Items arrive one at a time and each gives exactly one result
// item: load writes a sample word, play adds a voice (or is dropped when all voices are in use),
// shift moves the time reference and frame mixes every sounding voice into one saturated
// stereo frame. A frame walks the active voices one at a time through the voice memory and
// the sample memory, each a single-port read with registered data. The sample rate register
// is written through its own channel; the user must write it only while the block is idle,
// and the block itself does not enforce this. SAMPLE_DEPTH must be a power of two.
module scheduled_sample_voice_mixer_core #(
  parameter int unsigned VOICES       = 128,
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  ssvm_in_if.sink    in_ch,
  ssvm_out_if.source out_ch,
  ssvm_cfg_if.sink   cfg_ch
);

  ssvm_pkg::cmd_t  cmd;
  ssvm_pkg::sts_t  sts;
  ssvm_pkg::item_t item;

  // The input item is packed once here and latched by the datapath on acceptance.
  assign item.opcode       = in_ch.opcode;
  assign item.address      = in_ch.address;
  assign item.sound_length = in_ch.sound_length;
  assign item.sample_value = in_ch.sample_value;
  assign item.time_value   = in_ch.time_value;
  assign item.gain_left    = in_ch.gain_left;
  assign item.gain_right   = in_ch.gain_right;

  // The configuration register is always ready to take a write.
  assign cfg_ch.ready = 1'b1;

  ssvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssvm_dp #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .item          (item),
    .cfg_we        (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .left_out      (out_ch.left_out),
    .right_out     (out_ch.right_out),
    .status        (out_ch.status),
    .active_voices (out_ch.active_voices)
  );

  // One item is worked on at a time, so acceptance closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // A dropped play carries silent samples.
  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ssvm_pkg::ST_DROPPED)
      |-> (out_ch.left_out == '0) && (out_ch.right_out == '0))
    else $error("dropped play with nonzero samples");

  // A clipped frame has at least one channel on a rail.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ssvm_pkg::ST_CLIPPED)
      |-> (out_ch.left_out == 16'sh7FFF) || (out_ch.left_out == -16'sh8000)
       || (out_ch.right_out == 16'sh7FFF) || (out_ch.right_out == -16'sh8000))
    else $error("clip status without saturated channel");

endmodule
